// File: src/b64e_pkg.sv
// b64e_pkg: shared types, constants and the sextet-to-ascii function
// for the base64 stream encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  // queue between front and back, in jobs
  localparam int unsigned B64E_QUEUE_DEPTH = 2;

  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned MAX_CHARS = 4;
  localparam int unsigned IDX_W    = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

  // position within a three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // one classified input byte: up to four characters for the back end
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [IDX_W-1:0]                 last_idx;
    logic                             fin;
  } job_t;

  // standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] v7;
    logic [CHAR_W-1:0] res;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      res = v7 + 7'd65;
    end else if (v < 6'd52) begin
      res = v7 + 7'd71;
    end else if (v < 6'd62) begin
      res = v7 - 7'd4;
    end else if (v == 6'd62) begin
      res = 7'd43;
    end else begin
      res = 7'd47;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/b64e_front.sv
// b64e_front: accepts raw bytes, tracks group phase and carry bits,
// and builds one character job per byte; depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_final_byte,
  input  wire logic          take,
  output b64e_pkg::job_t     job
);
  import b64e_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  // character job and next group state for the incoming byte
  always_comb begin
    job       = '0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    job.fin   = in_final_byte;
    unique case (phase_r)
      PH_SECOND: begin
        job.chars[0] = sextet_char({carry_r[1:0], in_data_byte[7:4]});
        job.chars[1] = sextet_char({in_data_byte[3:0], 2'b00});
        job.chars[2] = PAD_CHAR;
        job.last_idx = in_final_byte ? 2'd2 : 2'd0;
        phase_nxt    = PH_THIRD;
        carry_nxt    = in_data_byte[3:0];
      end
      PH_THIRD: begin
        job.chars[0] = sextet_char({carry_r, in_data_byte[7:6]});
        job.chars[1] = sextet_char(in_data_byte[5:0]);
        job.last_idx = 2'd1;
        phase_nxt    = PH_FIRST;
        carry_nxt    = 4'd0;
      end
      default: begin
        job.chars[0] = sextet_char(in_data_byte[7:2]);
        job.chars[1] = sextet_char({in_data_byte[1:0], 4'b0000});
        job.chars[2] = PAD_CHAR;
        job.chars[3] = PAD_CHAR;
        job.last_idx = in_final_byte ? 2'd3 : 2'd0;
        phase_nxt    = PH_SECOND;
        carry_nxt    = {2'b00, in_data_byte[1:0]};
      end
    endcase
    // end of message restarts the group
    if (in_final_byte) begin
      phase_nxt = PH_FIRST;
      carry_nxt = 4'd0;
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= 4'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/b64e_queue.sv
// b64e_queue: short job fifo between front and back end
// depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire b64e_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               head_valid,
  output b64e_pkg::job_t     head_job
);
  import b64e_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: src/b64e_back.sv
// b64e_back: walks the head job into the output register one character per
// cycle while out_stall is low; depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            head_valid,
  input  wire b64e_pkg::job_t                  head_job,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [b64e_pkg::CHAR_W-1:0]          out_char,
  output logic                                 out_run_last,
  output logic                                 out_text_end
);
  import b64e_pkg::*;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r;
  logic              run_last_r, text_end_r;
  logic              load;
  logic              at_last;

  // output register is free when empty or being taken
  assign load    = head_valid && (!valid_r || !out_stall);
  assign at_last = (idx_r == head_job.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_last ? '0 : idx_r + 1'b1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      char_r     <= head_job.chars[idx_r];
      run_last_r <= at_last;
      text_end_r <= at_last && head_job.fin;
    end
  end

  assign out_valid    = valid_r;
  assign out_char     = char_r;
  assign out_run_last = run_last_r;
  assign out_text_end = text_end_r;

endmodule

`default_nettype wire

// File: src/base64_stream_encoder.sv
// base64_stream_encoder: top level, front classifier, job queue, back emitter
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
//
//   channel | ports                                        | role
//   input   | in_valid, in_stall, in_data_byte, in_final_byte | raw bytes in
//   output  | out_valid, out_stall, out_char, out_run_last, out_text_end | ascii out
//
// one byte is accepted per cycle while the job queue has room; the back end
// sends one character per cycle while the output is not stalled, and a byte yields one
// to four characters (four characters per three bytes on long messages).
// synchronous active-low reset clears the group phase, queue and output valid.
// stalls on the output fill the queue, and in_stall rises only when it is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_final_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [b64e_pkg::CHAR_W-1:0]          out_char,
  output logic                                 out_run_last,
  output logic                                 out_text_end
);
  import b64e_pkg::*;

  logic take;
  logic full;
  logic pop;
  logic head_valid;
  job_t new_job;
  job_t head_job;

  assign in_stall = full;
  assign take     = in_valid && !full;

  // front: classify the byte into a character job
  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .take          (take),
    .job           (new_job)
  );

  // queue between front and back
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_job   (new_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: emit characters
  b64e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

endmodule

`default_nettype wire

// File: test/base64_stream_encoder_test.sv
// base64_stream_encoder_test: self-checking bench for the streaming base64 encoder
// depends on b64e_pkg and base64_stream_encoder; predicts each character and
// its end flags per accepted byte and checks them against the output channel
`timescale 1ns / 1ps

module base64_stream_encoder_test;
  import b64e_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              run_last;
    logic              text_end;
  } b64_char_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte = 8'h00;
  logic              in_final_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_run_last;
  logic              out_text_end;

  // encoder state mirrored by the predictor
  phase_t     enc_phase = PH_FIRST;
  logic [3:0] enc_carry = 4'h0;

  b64_char_t  pending_chars[$];
  b64_char_t  want;

  // idling controls for the sender and the receiver
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  int hold_request = 0;
  int hold_left = 0;

  int error_count = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int chars_checked = 0;

  base64_stream_encoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  always #10 clk = ~clk;

  // map a six-bit value onto the standard alphabet
  function automatic logic [CHAR_W-1:0] b64_symbol(input logic [5:0] v);
    logic [7:0] sym;
    if (v < 6'd26) begin
      sym = "A" + {2'b00, v};
    end else if (v < 6'd52) begin
      sym = "a" + ({2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      sym = "0" + ({2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      sym = "+";
    end else begin
      sym = "/";
    end
    return sym[CHAR_W-1:0];
  endfunction

  // work out the characters one accepted byte causes and queue them
  function automatic void predict_chars(input logic [7:0] b, input logic fin);
    logic [CHAR_W-1:0] syms[MAX_CHARS];
    b64_char_t         item;
    int                n;
    n = 0;
    case (enc_phase)
      PH_SECOND: begin
        syms[0] = b64_symbol({enc_carry[1:0], b[7:4]});
        enc_carry = b[3:0];
        enc_phase = PH_THIRD;
        n = 1;
        if (fin) begin
          syms[1] = b64_symbol({b[3:0], 2'b00});
          syms[2] = PAD_CHAR;
          n = 3;
        end
      end
      PH_THIRD: begin
        syms[0] = b64_symbol({enc_carry, b[7:6]});
        syms[1] = b64_symbol(b[5:0]);
        enc_carry = 4'h0;
        enc_phase = PH_FIRST;
        n = 2;
      end
      default: begin
        // start of group, also taken for the unused phase value
        syms[0] = b64_symbol(b[7:2]);
        enc_carry = {2'b00, b[1:0]};
        enc_phase = PH_SECOND;
        n = 1;
        if (fin) begin
          syms[1] = b64_symbol({b[1:0], 4'h0});
          syms[2] = PAD_CHAR;
          syms[3] = PAD_CHAR;
          n = 4;
        end
      end
    endcase
    if (fin) begin
      enc_phase = PH_FIRST;
      enc_carry = 4'h0;
    end
    for (int k = 0; k < n; k++) begin
      item.ch = syms[k];
      item.run_last = (k == n - 1);
      item.text_end = (k == n - 1) && fin;
      pending_chars = {pending_chars, item};
    end
  endfunction

  // offer one byte, with random idle cycles ahead of it, until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!send_steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (in_stall);
    predict_chars(b, fin);
    bytes_sent++;
    if (fin) messages_sent++;
  endtask

  // one message of random bytes, with extremes mixed in
  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = $urandom_range(255);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // stop offering bytes and wait for every expected character
  task automatic drain_output();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // known vectors: final byte in each phase, byte extremes, message restart
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte("M", 1'b0);
    send_byte("a", 1'b0);
    send_byte("n", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_output();
  endtask

  // random messages, mostly short, a few long
  task automatic test_random_messages();
    int start;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < 40) begin
      case ($urandom_range(9))
        0: len = $urandom_range(13, 24);
        1, 2: len = $urandom_range(7, 12);
        default: len = $urandom_range(1, 6);
      endcase
      send_message(len);
    end
    drain_output();
  endtask

  // receiver holds off while the sender keeps offering, so the queue fills
  task automatic test_backpressure();
    send_steady = 1'b1;
    hold_request = 40;
    send_message(7);
    send_message(8);
    send_steady = 1'b0;
    drain_output();
  endtask

  // both sides at full rate
  task automatic test_steady();
    send_steady = 1'b1;
    recv_steady = 1'b1;
    for (int m = 0; m < 10; m++) send_message($urandom_range(1, 5));
    drain_output();
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  // receiver: long hold-off on request, else random or no stalls
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (recv_steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 29);
    end
  end

  // compare each output transaction with the oldest expected character
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, actual char=%0d run_last=%0b text_end=%0b",
                 $time, out_char, out_run_last, out_text_end);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_char !== want.ch) begin
          $display("%0t: char mismatch, expected %0d actual %0d", $time, want.ch, out_char);
          error_count++;
        end
        if (out_run_last !== want.run_last) begin
          $display("%0t: run_last mismatch, expected %0b actual %0b",
                   $time, want.run_last, out_run_last);
          error_count++;
        end
        if (out_text_end !== want.text_end) begin
          $display("%0t: text_end mismatch, expected %0b actual %0b",
                   $time, want.text_end, out_text_end);
          error_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_messages();
    test_backpressure();
    test_steady();
    repeat (20) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, pending_chars.size());
      error_count++;
    end
    $display("covered %0d bytes in %0d messages, %0d characters checked",
             bytes_sent, messages_sent, chars_checked);
    $display("final byte in every group position, long output hold-off, full-rate stretch");
    if (error_count == 0) begin
      $display("base64_stream_encoder_test: done, clean");
    end else begin
      $display("base64_stream_encoder_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("base64_stream_encoder_test: done, errors");
    $finish;
  end

endmodule

// File: files.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
test/base64_stream_encoder_test.sv
